// ===== hdl/bhe_pkg.sv =====
// shared types, constants and helpers of the binary heap engine
package bhe_pkg;

    localparam int CAPACITY    = 15;
    localparam int KEY_W       = 32;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int KID_W       = IDX_W + 1;
    localparam int COUNT_OUT_W = 4;
    localparam int MODE_W      = 3;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 2;

    localparam logic [APB_ADDR_W-1:0] ADDR_ORDER = '0;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR   = 3'd0,
        MODE_INSERT  = 3'd1,
        MODE_APPEND  = 3'd2,
        MODE_HEAPIFY = 3'd3,
        MODE_CHECK   = 3'd4
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_HP_LOAD,
        ST_HP_KEY,
        ST_SD_KID,
        ST_SD_A,
        ST_SD_B,
        ST_SD_CMP,
        ST_CK_P,
        ST_CK_PV,
        ST_CK_A,
        ST_CK_B,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                    we;
        logic [IDX_W-1:0]        waddr;
        logic signed [KEY_W-1:0] wdata;
        logic [IDX_W-1:0]        raddr;
    } t_mem_req;

    // true if key a belongs above key b under the selected order
    function automatic logic precedes(input logic signed [KEY_W-1:0] a,
                                      input logic signed [KEY_W-1:0] b,
                                      input logic                    is_max);
        logic res;
        res = is_max ? (a > b) : (a < b);
        return res;
    endfunction

endpackage

// ===== hdl/binary_heap_engine.sv =====
// binary heap engine top level: sequencer, configuration port and result register
//
// Binary heap of up to 15 signed 32-bit keys held in a RAM with one write port and
// one registered read port; every memory access of every operation goes through
// those two ports. Each item gives one result in the result register.
// Clear, raw append, unused modes and a dropped insert go straight to done. Insert
// reads the parent per level, moves it down while the key outranks it, then writes the key.
// Heapify sinks each internal node from the last to the root, reading one or both
// children per level and writing the key back where it stops or at a leaf.
// Check walks the internal nodes from the root, reads each parent and its children
// one word a cycle, and stops at the first violation.
// A new item is taken once the previous result sits in the output register.
// order_is_max is at byte address 0.
module binary_heap_engine
    import bhe_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [MODE_W-1:0]            i_mode,
    input  logic signed [KEY_W-1:0]      i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_accepted,
    output logic [COUNT_OUT_W-1:0]       o_element_count,
    output logic                         o_heap_ok,
    output logic signed [KEY_W-1:0]      o_root_value,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready
);

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [IDX_W-1:0]        r_pos, n_pos;
    logic [IDX_W-1:0]        r_p, n_p;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic signed [KEY_W-1:0] r_best, n_best;
    logic [IDX_W-1:0]        r_best_idx, n_best_idx;
    logic                    r_ok, n_ok;
    logic                    r_acc, n_acc;
    logic                    r_order;

    logic                    r_out_valid;
    logic                    r_out_accepted;
    logic [CNT_W-1:0]        r_out_count;
    logic                    r_out_ok;
    logic signed [KEY_W-1:0] r_out_root;

    t_mem_req                mem_req;
    logic signed [KEY_W-1:0] mem_rdata;
    logic signed [KEY_W-1:0] mem_root;

    logic                    in_acc;
    logic                    full;
    logic                    out_free;
    logic [IDX_W-1:0]        ins_up;
    logic [KID_W-1:0]        sd_kid;
    logic [KID_W:0]          sd_sib;
    logic                    sd_has_kid;
    logic                    sd_has_sib;
    logic [KID_W-1:0]        ck_kid;
    logic [KID_W:0]          ck_sib;
    logic                    ck_has_kid;
    logic                    ck_has_sib;
    logic                    rd_beats_key;
    logic                    key_beats_rd;
    logic                    rd_beats_best;
    logic                    best_beats_key;
    logic                    cfg_wr;

    bhe_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata),
        .o_root  (mem_root)
    );

    assign in_acc     = i_in_valid && (r_state == ST_IDLE);
    assign full       = r_count >= CNT_W'(CAPACITY);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign ins_up     = IDX_W'((r_pos - IDX_W'(1)) >> 1);
    assign sd_kid     = {r_pos, 1'b1};
    assign sd_sib     = {1'b0, sd_kid} + (KID_W+1)'(1);
    assign sd_has_kid = sd_kid < KID_W'(r_count);
    assign sd_has_sib = sd_sib < (KID_W+1)'(r_count);
    assign ck_kid     = {r_p, 1'b1};
    assign ck_sib     = {1'b0, ck_kid} + (KID_W+1)'(1);
    assign ck_has_kid = ck_kid < KID_W'(r_count);
    assign ck_has_sib = ck_sib < (KID_W+1)'(r_count);

    assign rd_beats_key   = precedes(mem_rdata, r_key, r_order);
    assign key_beats_rd   = precedes(r_key, mem_rdata, r_order);
    assign rd_beats_best  = precedes(mem_rdata, r_best, r_order);
    assign best_beats_key = precedes(r_best, r_key, r_order);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_mode)
                        MODE_INSERT:  n_state = full ? ST_DONE : ST_INS_RD;
                        MODE_HEAPIFY: n_state = (r_count < CNT_W'(2)) ? ST_DONE : ST_HP_LOAD;
                        MODE_CHECK:   n_state = ST_CK_P;
                        default:      n_state = ST_DONE;
                    endcase
                end
            end
            ST_INS_RD:  n_state = (r_pos == '0) ? ST_DONE : ST_INS_CMP;
            ST_INS_CMP: n_state = key_beats_rd ? ST_INS_RD : ST_DONE;
            ST_HP_LOAD: n_state = ST_HP_KEY;
            ST_HP_KEY:  n_state = ST_SD_KID;
            ST_SD_KID: begin
                if (sd_has_kid) begin
                    n_state = ST_SD_A;
                end else begin
                    n_state = (r_p == '0) ? ST_DONE : ST_HP_LOAD;
                end
            end
            ST_SD_A:    n_state = sd_has_sib ? ST_SD_B : ST_SD_CMP;
            ST_SD_B:    n_state = ST_SD_CMP;
            ST_SD_CMP: begin
                if (best_beats_key) begin
                    n_state = ST_SD_KID;
                end else begin
                    n_state = (r_p == '0) ? ST_DONE : ST_HP_LOAD;
                end
            end
            ST_CK_P:    n_state = ck_has_kid ? ST_CK_PV : ST_DONE;
            ST_CK_PV:   n_state = ST_CK_A;
            ST_CK_A: begin
                if (rd_beats_key) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ck_has_sib ? ST_CK_B : ST_CK_P;
                end
            end
            ST_CK_B:    n_state = rd_beats_key ? ST_DONE : ST_CK_P;
            ST_DONE:    n_state = out_free ? ST_IDLE : ST_DONE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count    = r_count;
        n_pos      = r_pos;
        n_p        = r_p;
        n_key      = r_key;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_ok       = r_ok;
        n_acc      = r_acc;
        mem_req    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_ok  = 1'b0;
                    n_acc = 1'b1;
                    n_key = i_value;
                    n_pos = IDX_W'(r_count);
                    n_p   = '0;
                    unique case (i_mode)
                        MODE_CLEAR: n_count = '0;
                        MODE_INSERT: n_acc = !full;
                        MODE_APPEND: begin
                            n_acc = !full;
                            if (!full) begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = IDX_W'(r_count);
                                mem_req.wdata = i_value;
                                n_count       = r_count + CNT_W'(1);
                            end
                        end
                        MODE_HEAPIFY: n_p = IDX_W'((r_count - CNT_W'(2)) >> 1);
                        default: ;
                    endcase
                end
            end
            ST_INS_RD: begin
                if (r_pos == '0) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = r_pos;
                    mem_req.wdata = r_key;
                    n_count       = r_count + CNT_W'(1);
                end else begin
                    mem_req.raddr = ins_up;
                end
            end
            ST_INS_CMP: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_pos;
                if (key_beats_rd) begin
                    mem_req.wdata = mem_rdata;
                    n_pos         = ins_up;
                end else begin
                    mem_req.wdata = r_key;
                    n_count       = r_count + CNT_W'(1);
                end
            end
            ST_HP_LOAD: begin
                mem_req.raddr = r_p;
                n_pos         = r_p;
            end
            ST_HP_KEY: n_key = mem_rdata;
            ST_SD_KID: begin
                if (sd_has_kid) begin
                    mem_req.raddr = sd_kid[IDX_W-1:0];
                end else begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = r_pos;
                    mem_req.wdata = r_key;
                    n_p           = r_p - IDX_W'(1);
                end
            end
            ST_SD_A: begin
                n_best     = mem_rdata;
                n_best_idx = sd_kid[IDX_W-1:0];
                if (sd_has_sib) begin
                    mem_req.raddr = sd_sib[IDX_W-1:0];
                end
            end
            ST_SD_B: begin
                if (rd_beats_best) begin
                    n_best     = mem_rdata;
                    n_best_idx = sd_sib[IDX_W-1:0];
                end
            end
            ST_SD_CMP: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_pos;
                if (best_beats_key) begin
                    mem_req.wdata = r_best;
                    n_pos         = r_best_idx;
                end else begin
                    mem_req.wdata = r_key;
                    n_p           = r_p - IDX_W'(1);
                end
            end
            ST_CK_P: begin
                if (ck_has_kid) begin
                    mem_req.raddr = r_p;
                end else begin
                    n_ok = 1'b1;
                end
            end
            ST_CK_PV: begin
                n_key         = mem_rdata;
                mem_req.raddr = ck_kid[IDX_W-1:0];
            end
            ST_CK_A: begin
                if (!rd_beats_key) begin
                    if (ck_has_sib) begin
                        mem_req.raddr = ck_sib[IDX_W-1:0];
                    end else begin
                        n_p = r_p + IDX_W'(1);
                    end
                end
            end
            ST_CK_B: begin
                if (!rd_beats_key) begin
                    n_p = r_p + IDX_W'(1);
                end
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_order     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (cfg_wr) begin
                r_order <= pwdata[0];
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_p        <= n_p;
        r_key      <= n_key;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_ok       <= n_ok;
        r_acc      <= n_acc;
        if (r_state == ST_DONE && out_free) begin
            r_out_accepted <= r_acc;
            r_out_count    <= r_count;
            r_out_ok       <= r_ok;
            r_out_root     <= (r_count == '0) ? '0 : mem_root;
        end
    end

    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_ORDER);
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ORDER) ? APB_DATA_W'(r_order) : '0;

    assign o_in_stall      = r_state != ST_IDLE;
    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_out_accepted;
    assign o_element_count = COUNT_OUT_W'(r_out_count);
    assign o_heap_ok       = r_out_ok;
    assign o_root_value    = r_out_root;

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == '0 || r_count == $past(r_count) + CNT_W'(1)))
        else $error("element count moved by more than one");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && i_out_stall) |=> (r_state == ST_DONE))
        else $error("sequencer left done while result was stalled");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.we |-> (CNT_W'(mem_req.waddr) <= r_count))
        else $error("store write beyond element count");
`endif

endmodule

// ===== hdl/bhe_store.sv =====
// key store: single write, single registered read port, shadow of the root entry
module bhe_store
    import bhe_pkg::*;
(
    input  logic                    i_clk,
    input  t_mem_req                i_req,
    output logic signed [KEY_W-1:0] o_rdata,
    output logic signed [KEY_W-1:0] o_root
);

    logic signed [KEY_W-1:0] r_mem [CAPACITY];
    logic signed [KEY_W-1:0] r_rdata;
    logic signed [KEY_W-1:0] r_root;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we && i_req.waddr == '0) begin
            r_root <= i_req.wdata;
        end
    end

    assign o_rdata = r_rdata;
    assign o_root  = r_root;

endmodule

// ===== test/binary_heap_engine_test.sv =====
// self-checking testbench of the binary heap engine against a heap predictor
module binary_heap_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bhe_pkg::*;

    localparam int              ITEM_TARGET  = 1050;
    localparam int              MAX_IDLE     = 18;
    localparam int              SETTLE       = 40;
    localparam int              SQUEEZE_AT   = 300;
    localparam int              SQUEEZE_LEN  = 400;
    localparam int unsigned     LIMIT_CYCLES = 1_000_000;
    localparam int unsigned     SHOW_LIMIT   = 10;

    localparam logic [APB_ADDR_W-1:0] REG_ORDER     = '0;
    localparam logic [MODE_W-1:0]     MODE_SPARE_LO = MODE_W'(MODE_CHECK + 1);
    localparam logic [MODE_W-1:0]     MODE_SPARE_HI = '1;

    localparam logic signed [KEY_W-1:0] KEY_TOP    = {1'b0, {(KEY_W-1){1'b1}}};
    localparam logic signed [KEY_W-1:0] KEY_BOTTOM = {1'b1, {(KEY_W-1){1'b0}}};

    typedef struct packed {
        logic                    accepted;
        logic [COUNT_OUT_W-1:0]  count;
        logic                    heap_ok;
        logic signed [KEY_W-1:0] root;
    } t_heap_result;

    class heap_scoreboard;
        logic signed [KEY_W-1:0] keys [CAPACITY];
        int unsigned             fill         = 0;
        logic                    order_max    = 1'b0;
        t_heap_result            awaited [$];
        int unsigned             mismatches   = 0;
        int unsigned             matched      = 0;
        int unsigned             drops        = 0;
        int unsigned             broken_heaps = 0;

        function bit outranks(logic signed [KEY_W-1:0] a, logic signed [KEY_W-1:0] b);
            return order_max ? (a > b) : (a < b);
        endfunction

        function void sift_in(logic signed [KEY_W-1:0] key);
            int unsigned pos;
            int unsigned up;
            pos = fill;
            while (pos > 0) begin
                up = (pos - 1) / 2;
                if (!outranks(key, keys[up]))
                    break;
                keys[pos] = keys[up];
                pos = up;
            end
            keys[pos] = key;
            fill++;
        endfunction

        function void sink(int unsigned start);
            int unsigned             pos;
            int unsigned             kid;
            logic signed [KEY_W-1:0] tmp;
            pos = start;
            while (pos * 2 + 1 < fill) begin
                kid = pos * 2 + 1;
                if (kid + 1 < fill && outranks(keys[kid + 1], keys[kid]))
                    kid++;
                if (!outranks(keys[kid], keys[pos]))
                    break;
                tmp       = keys[pos];
                keys[pos] = keys[kid];
                keys[kid] = tmp;
                pos       = kid;
            end
        endfunction

        function void rebuild();
            if (fill < 2)
                return;
            for (int p = int'((fill - 2) / 2); p >= 0; p--)
                sink(p);
        endfunction

        function bit ordered();
            for (int unsigned p = 0; p * 2 + 1 < fill; p++) begin
                if (outranks(keys[p * 2 + 1], keys[p]))
                    return 1'b0;
                if (p * 2 + 2 < fill && outranks(keys[p * 2 + 2], keys[p]))
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_item(logic [MODE_W-1:0] mode, logic signed [KEY_W-1:0] key);
            t_heap_result r;
            r.accepted = 1'b1;
            r.heap_ok  = 1'b0;
            case (mode)
                MODE_CLEAR: fill = 0;
                MODE_INSERT: begin
                    if (fill >= CAPACITY)
                        r.accepted = 1'b0;
                    else
                        sift_in(key);
                end
                MODE_APPEND: begin
                    if (fill >= CAPACITY) begin
                        r.accepted = 1'b0;
                    end else begin
                        keys[fill] = key;
                        fill++;
                    end
                end
                MODE_HEAPIFY: rebuild();
                MODE_CHECK: begin
                    r.heap_ok = ordered();
                    if (!r.heap_ok)
                        broken_heaps++;
                end
                default: ;
            endcase
            if (!r.accepted)
                drops++;
            r.count = COUNT_OUT_W'(fill);
            r.root  = (fill > 0) ? keys[0] : '0;
            awaited.push_back(r);
        endfunction

        function void check_result(t_heap_result got);
            t_heap_result want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("result with no item pending: accepted %b count %0d",
                             got.accepted, got.count,
                             " ok %b root %0d", got.heap_ok, got.root);
                return;
            end
            want = awaited.pop_front();
            if (got.accepted !== want.accepted || got.count !== want.count ||
                got.heap_ok !== want.heap_ok || got.root !== want.root) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("result %0d mismatch (exp/got): accepted %b/%b count %0d/%0d",
                             matched + mismatches, want.accepted, got.accepted,
                             want.count, got.count,
                             " ok %b/%b root %0d/%0d", want.heap_ok, got.heap_ok,
                             want.root, got.root);
            end else begin
                matched++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [MODE_W-1:0]       i_mode;
    logic signed [KEY_W-1:0] i_value;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic                    o_accepted;
    logic [COUNT_OUT_W-1:0]  o_element_count;
    logic                    o_heap_ok;
    logic signed [KEY_W-1:0] o_root_value;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    heap_scoreboard sb = new();
    bit             sender_quiet;
    int unsigned    items_sent    = 0;
    int unsigned    results_taken = 0;
    int unsigned    order_writes  = 0;
    int unsigned    cycle_count   = 0;

    binary_heap_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_accepted      (o_accepted),
        .o_element_count (o_element_count),
        .o_heap_ok       (o_heap_ok),
        .o_root_value    (o_root_value),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    function automatic logic signed [KEY_W-1:0] draw_key();
        case ($urandom_range(0, 7))
            0: return KEY_TOP;
            1: return KEY_BOTTOM;
            2, 3: return KEY_W'($urandom_range(0, 8)) - KEY_W'(4);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [MODE_W-1:0] mode, input logic signed [KEY_W-1:0] key);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_value    <= key;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(mode, key);
        items_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_order(input logic is_max);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_ORDER;
        pwdata  <= APB_DATA_W'(is_max);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.order_max = is_max;
        order_writes++;
    endtask

    // fill from an optional clear, then check, and heapify what was appended unordered
    task automatic run_sequence();
        int n;
        bit sifting;
        n       = $urandom_range(0, CAPACITY + 3);
        sifting = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) != 0)
            send_item(MODE_CLEAR, draw_key());
        for (int k = 0; k < n; k++) begin
            send_item(sifting ? MODE_INSERT : MODE_APPEND, draw_key());
            if ($urandom_range(0, 5) == 0)
                send_item(MODE_CHECK, draw_key());
        end
        send_item(MODE_CHECK, draw_key());
        if (!sifting) begin
            send_item(MODE_HEAPIFY, draw_key());
            send_item(MODE_CHECK, draw_key());
        end
    endtask

    task automatic run_noise();
        int n;
        n = $urandom_range(1, 8);
        repeat (n) send_item(MODE_W'($urandom_range(0, 7)), draw_key());
    endtask

    initial begin : stimulus
        int unsigned next_switch;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_mode       <= MODE_CLEAR;
        i_value      <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= REG_ORDER;
        pwdata       <= '0;
        sender_quiet = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // min order: empty store, single element, extremes, ties, unordered data, spare modes
        write_order(1'b0);
        send_item(MODE_CLEAR, KEY_TOP);
        send_item(MODE_CHECK, KEY_BOTTOM);
        send_item(MODE_HEAPIFY, '0);
        send_item(MODE_INSERT, KEY_TOP);
        send_item(MODE_CHECK, '0);
        send_item(MODE_HEAPIFY, '0);
        send_item(MODE_INSERT, KEY_BOTTOM);
        send_item(MODE_INSERT, 7);
        send_item(MODE_INSERT, 7);
        send_item(MODE_INSERT, KEY_BOTTOM);
        send_item(MODE_APPEND, 100);
        send_item(MODE_APPEND, -100);
        send_item(MODE_CHECK, '0);
        send_item(MODE_HEAPIFY, '0);
        send_item(MODE_CHECK, '0);
        send_item(MODE_SPARE_LO, KEY_TOP);
        send_item(MODE_W'(MODE_SPARE_LO + 1), '0);
        send_item(MODE_SPARE_HI, KEY_BOTTOM);
        send_item(MODE_CLEAR, '0);

        // max order on a fresh store
        drain();
        write_order(1'b1);
        send_item(MODE_APPEND, 1);
        send_item(MODE_APPEND, 2);
        send_item(MODE_APPEND, 3);
        send_item(MODE_CHECK, '0);
        send_item(MODE_HEAPIFY, '0);
        send_item(MODE_CHECK, '0);
        send_item(MODE_INSERT, 5);

        // order switches keep the stored data
        next_switch = items_sent + 100;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= next_switch) begin
                drain();
                write_order(1'($urandom_range(0, 1)));
                next_switch = items_sent + $urandom_range(80, 200);
            end
            sender_quiet = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 9) < 7)
                run_sequence();
            else
                run_noise();
        end

        drain();
        $display("run covered %0d items and %0d results,", items_sent, results_taken,
                 " %0d dropped on a full store, %0d failing checks",
                 sb.drops, sb.broken_heaps);
        $display("order register written %0d times, %0d mismatches", order_writes, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : result_side
        int           hold;
        bit           quiet;
        t_heap_result got;
        hold  = 0;
        quiet = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.accepted = o_accepted;
                got.count    = o_element_count;
                got.heap_ok  = o_heap_ok;
                got.root     = o_root_value;
                sb.check_result(got);
                results_taken++;
                if (results_taken % 50 == 0)
                    quiet = ($urandom_range(0, 2) == 0);
                // one long hold lets the block back up into its input
                if (results_taken == SQUEEZE_AT)
                    hold = SQUEEZE_LEN;
                else
                    hold = quiet ? 0 : $urandom_range(0, MAX_IDLE);
            end
            i_out_stall <= (hold > 0);
            if (hold > 0)
                hold--;
        end
    end

    initial begin : watchdog
        wait (cycle_count >= LIMIT_CYCLES);
        $display("timeout after %0d cycles, %0d results still pending", cycle_count, sb.pending());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/bhe_pkg.sv
hdl/bhe_store.sv
hdl/binary_heap_engine.sv
test/binary_heap_engine_test.sv
